// File: hw/rtl/tct_pkg.sv
// Shared types, character codes and cell functions of the tap code translator.
// No dependencies; used by all tct_* modules and the top level.
package tct_pkg;

    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpZ   = 8'h5A;
    localparam logic [7:0] CharA     = 8'h61;
    localparam logic [7:0] CharK     = 8'h6B;
    localparam logic [7:0] CharZ     = 8'h7A;

    localparam logic [2:0] TapSide = 3'd5;
    localparam logic [2:0] TapSat  = 3'd6;

    localparam int CmdDepth = 4;

    // One command from the front: what the back has to emit for one item.
    typedef struct packed {
        logic       dec_valid;
        logic [7:0] dec_char;
        logic       enc_valid;
        logic [2:0] enc_row;    // 0..4
        logic [2:0] enc_col;    // 0..4
        logic       enc_space;
        logic       term;
    } tct_cmd_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } tct_cell_t;

    // Row and column counts 1..5 to a lowercase letter, skipping k.
    function automatic logic [7:0] decode_cell(input logic [2:0] row, input logic [2:0] col);
        logic [4:0] r0;
        logic [4:0] idx;
        r0  = {2'b00, row - 3'd1};
        idx = (r0 << 2) + r0 + {2'b00, col - 3'd1};
        if (idx >= 5'd10)
            idx = idx + 5'd1;
        return CharA + {3'b000, idx};
    endfunction

    // Lowercase letter to its zero-based cell; k shares the cell of c.
    function automatic tct_cell_t encode_cell(input logic [7:0] lc);
        logic [4:0] idx;
        tct_cell_t  pos;
        idx = lc[4:0] - 5'd1;
        if (lc == CharK)
            idx = 5'd2;
        else if (lc > CharK)
            idx = idx - 5'd1;
        if (idx >= 5'd20) begin
            pos.row = 3'd4;
            pos.col = 3'(idx - 5'd20);
        end else if (idx >= 5'd15) begin
            pos.row = 3'd3;
            pos.col = 3'(idx - 5'd15);
        end else if (idx >= 5'd10) begin
            pos.row = 3'd2;
            pos.col = 3'(idx - 5'd10);
        end else if (idx >= 5'd5) begin
            pos.row = 3'd1;
            pos.col = 3'(idx - 5'd5);
        end else begin
            pos.row = 3'd0;
            pos.col = 3'(idx);
        end
        return pos;
    endfunction

endpackage

// File: hw/rtl/tap_code_translator.sv
// Top level of the tap code translator: front end, command queue, back end.
// Depends on tct_pkg, tct_front, tct_cmd_fifo and tct_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------
//   input    | push / full          | in_char, in_last
//   result   | empty / pop          | out_char, run_last
//
// The front end takes one character per cycle while the queue has room.
// The back end emits one result beat per cycle while the result side keeps popping,
// through the single output register; a letter that closes a group and ends the
// message produces up to 13 beats, dots and spaces 1 to 2.
// Items that produce nothing never enter the queue.
// Reset clears the group state and empties the queue and the output register at once.
module tap_code_translator
#(
    parameter int CMD_DEPTH = tct_pkg::CmdDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       run_last
);

    logic              accept;
    logic              cmd_push;
    tct_pkg::tct_cmd_t cmd_in;
    tct_pkg::tct_cmd_t cmd_head;
    logic              cmd_avail;
    logic              cmd_take;
    logic              cmd_full;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    tct_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_char   (in_char),
        .in_last   (in_last),
        .cmd_valid (cmd_push),
        .cmd       (cmd_in)
    );

    tct_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_push),
        .wr_data   (cmd_in),
        .full      (cmd_full),
        .rd_en     (cmd_take),
        .rd_data   (cmd_head),
        .not_empty (cmd_avail)
    );

    tct_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd       (cmd_head),
        .cmd_take  (cmd_take),
        .out_char  (out_char),
        .run_last  (run_last),
        .empty     (empty),
        .pop       (pop)
    );

    // a terminator always closes the run of its item
    a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_char == tct_pkg::CharNul) |-> run_last)
        else $error("terminator beat without run_last");

    // a final character always queues a command
    a_last_queues: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && in_last) |=> cmd_avail)
        else $error("final character produced no command");

    // the back end never pulls from an empty queue
    a_take_avail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> (cmd_avail && !(cmd_full && cmd_push && !cmd_take)))
        else $error("command taken from empty queue");

endmodule

// File: hw/rtl/tct_front.sv
// Front end: classifies each accepted character, tracks the pending dot group
// and builds at most one command per item. Depends on tct_pkg.
module tct_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         in_char,
    input  logic               in_last,
    output logic               cmd_valid,
    output tct_pkg::tct_cmd_t  cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ROW  = 2'd1;
    localparam logic [1:0] PH_COL  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [2:0] row_reg, row_next;
    logic [2:0] col_reg, col_next;

    logic [1:0] phase_eff;
    logic [1:0] grp_phase;
    logic [2:0] grp_row;
    logic [2:0] grp_col;
    logic       is_dot;
    logic       is_sep;
    logic       closing;
    logic       is_letter;
    logic [7:0] lc;
    tct_pkg::tct_cell_t enc_pos;

    always_comb
    begin
        phase_eff = (phase_reg == PH_ROW || phase_reg == PH_COL) ? phase_reg : PH_IDLE;
        is_dot    = (in_char == tct_pkg::CharDot);
        is_sep    = (in_char == tct_pkg::CharSpace) && (phase_eff == PH_ROW);

        lc = in_char;
        if (in_char >= tct_pkg::CharUpA && in_char <= tct_pkg::CharUpZ)
            lc = in_char | 8'h20;
        is_letter = (lc >= tct_pkg::CharA) && (lc <= tct_pkg::CharZ);
        enc_pos   = tct_pkg::encode_cell(lc);

        // group as it stands after this character
        grp_phase = phase_eff;
        grp_row   = row_reg;
        grp_col   = col_reg;
        if (is_dot) begin
            unique case (phase_eff)
                PH_IDLE:
                begin
                    grp_phase = PH_ROW;
                    grp_row   = 3'd1;
                    grp_col   = 3'd0;
                end
                PH_ROW:
                begin
                    if (row_reg < tct_pkg::TapSat)
                        grp_row = row_reg + 3'd1;
                end
                default:
                begin
                    if (col_reg < tct_pkg::TapSat)
                        grp_col = col_reg + 3'd1;
                end
            endcase
        end else if (is_sep) begin
            grp_phase = PH_COL;
        end

        closing = !(is_dot || is_sep) || in_last;

        cmd.dec_valid = closing && (grp_phase != PH_IDLE)
                        && (grp_row >= 3'd1) && (grp_row <= tct_pkg::TapSide)
                        && (grp_col >= 3'd1) && (grp_col <= tct_pkg::TapSide);
        cmd.dec_char  = tct_pkg::decode_cell(grp_row, grp_col);
        cmd.enc_valid = !(is_dot || is_sep) && is_letter;
        cmd.enc_row   = enc_pos.row;
        cmd.enc_col   = enc_pos.col;
        cmd.enc_space = !in_last;
        cmd.term      = in_last;

        cmd_valid = accept && (cmd.dec_valid || cmd.enc_valid || cmd.term);

        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (accept) begin
            phase_next = closing ? PH_IDLE : grp_phase;
            row_next   = closing ? 3'd0 : grp_row;
            col_next   = closing ? 3'd0 : grp_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            row_reg   <= 3'd0;
            col_reg   <= 3'd0;
        end else begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

endmodule

// File: hw/rtl/tct_cmd_fifo.sv
// Short command queue between front and back ends.
// Depends on tct_pkg for the command type.
module tct_cmd_fifo
#(
    parameter int DEPTH = tct_pkg::CmdDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  tct_pkg::tct_cmd_t  wr_data,
    output logic               full,
    input  logic               rd_en,
    output tct_pkg::tct_cmd_t  rd_data,
    output logic               not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCount = CW'(DEPTH);

    tct_pkg::tct_cmd_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FullCount);
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LastAddr) ? '0 : wr_ptr_reg + AW'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LastAddr) ? '0 : rd_ptr_reg + AW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CW'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/tct_back.sv
// Back end: steps through one command a beat at a time into the output register.
// Depends on tct_pkg.
module tct_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_avail,
    input  tct_pkg::tct_cmd_t  cmd,
    output logic               cmd_take,
    output logic [7:0]         out_char,
    output logic               run_last,
    output logic               empty,
    input  logic               pop
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_ROW  = 3'd2;
    localparam logic [2:0] ST_SEP  = 3'd3;
    localparam logic [2:0] ST_COL  = 3'd4;
    localparam logic [2:0] ST_TSP  = 3'd5;
    localparam logic [2:0] ST_TERM = 3'd6;

    logic [2:0]        stage_reg, stage_next;
    logic [2:0]        cnt_reg, cnt_next;
    tct_pkg::tct_cmd_t cmd_reg, cmd_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              run_last_reg, run_last_next;
    logic              out_valid_reg, out_valid_next;

    logic       advance;
    logic       busy;
    logic [2:0] stage_follow;
    logic [2:0] cnt_follow;
    logic [7:0] beat_char;

    function automatic logic [2:0] tail_stage(input tct_pkg::tct_cmd_t c);
        return c.term ? ST_TERM : ST_IDLE;
    endfunction

    function automatic logic [2:0] after_dec(input tct_pkg::tct_cmd_t c);
        return c.enc_valid ? ST_ROW : tail_stage(c);
    endfunction

    function automatic logic [2:0] first_stage(input tct_pkg::tct_cmd_t c);
        return c.dec_valid ? ST_DEC : after_dec(c);
    endfunction

    assign out_char = out_char_reg;
    assign run_last = run_last_reg;
    assign empty    = !out_valid_reg;

    always_comb
    begin
        advance = !out_valid_reg || pop;
        busy    = (stage_reg != ST_IDLE);

        stage_follow = ST_IDLE;
        cnt_follow   = 3'd0;
        beat_char    = tct_pkg::CharNul;
        unique case (stage_reg)
            ST_IDLE:
            begin
                stage_follow = ST_IDLE;
            end
            ST_DEC:
            begin
                beat_char    = cmd_reg.dec_char;
                stage_follow = after_dec(cmd_reg);
            end
            ST_ROW:
            begin
                beat_char = tct_pkg::CharDot;
                if (cnt_reg == cmd_reg.enc_row) begin
                    stage_follow = ST_SEP;
                end else begin
                    stage_follow = ST_ROW;
                    cnt_follow   = cnt_reg + 3'd1;
                end
            end
            ST_SEP:
            begin
                beat_char    = tct_pkg::CharSpace;
                stage_follow = ST_COL;
            end
            ST_COL:
            begin
                beat_char = tct_pkg::CharDot;
                if (cnt_reg == cmd_reg.enc_col) begin
                    stage_follow = cmd_reg.enc_space ? ST_TSP : tail_stage(cmd_reg);
                end else begin
                    stage_follow = ST_COL;
                    cnt_follow   = cnt_reg + 3'd1;
                end
            end
            ST_TSP:
            begin
                beat_char    = tct_pkg::CharSpace;
                stage_follow = tail_stage(cmd_reg);
            end
            ST_TERM:
            begin
                beat_char    = tct_pkg::CharNul;
                stage_follow = ST_IDLE;
            end
            default:
            begin
                stage_follow = ST_IDLE;
            end
        endcase

        // take the next command on the final beat of this one, no bubble
        cmd_take = cmd_avail && (!busy || (advance && stage_follow == ST_IDLE));

        stage_next     = stage_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        out_char_next  = out_char_reg;
        run_last_next  = run_last_reg;
        out_valid_next = out_valid_reg;

        if (busy && advance) begin
            stage_next     = stage_follow;
            cnt_next       = cnt_follow;
            out_char_next  = beat_char;
            run_last_next  = (stage_follow == ST_IDLE);
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end

        if (cmd_take) begin
            cmd_next   = cmd;
            stage_next = first_stage(cmd);
            cnt_next   = 3'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_char_reg <= out_char_next;
        run_last_reg <= run_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            stage_reg     <= stage_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: tb/tap_code_checker.sv
// Checker for the tap code translator: watches both queue channels, predicts
// the result beats of every accepted character and compares them in order.
// Depends on tct_pkg for the character codes and the square constants.
module tap_code_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_char,
    input  logic       run_last,
    output int         pending_beats,
    output int         fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tct_pkg::*;

    typedef enum logic [1:0] {
        PhaseIdle  = 2'd0,
        PhaseRow   = 2'd1,
        PhaseCol   = 2'd2,
        PhaseSpare = 2'd3
    } group_phase_e;

    typedef struct {
        logic [7:0] code;
        logic       last_flag;
    } beat_t;

    group_phase_e phase;
    logic [2:0]   row_cnt;
    logic [2:0]   col_cnt;
    logic [7:0]   step_chars[$];
    beat_t        expected_beats[$];

    task automatic emit_char(input logic [7:0] c);
        step_chars.push_back(c);
    endtask

    task automatic close_group();
        int idx;
        if ((phase == PhaseRow || phase == PhaseCol) &&
            row_cnt >= 3'd1 && row_cnt <= TapSide &&
            col_cnt >= 3'd1 && col_cnt <= TapSide) begin
            idx = (int'(row_cnt) - 1) * int'(TapSide) + (int'(col_cnt) - 1);
            // skip k: it shares the cell of c
            if (idx >= 10)
                idx++;
            emit_char(8'(int'(CharA) + idx));
        end
        phase   = PhaseIdle;
        row_cnt = 3'd0;
        col_cnt = 3'd0;
    endtask

    task automatic encode_letter(input logic [7:0] lc, input logic last_flag);
        int idx;
        int r;
        int c;
        if (lc == CharK)
            lc = CharA + 8'd2;
        idx = int'(lc) - int'(CharA);
        if (lc >= CharK)
            idx--;
        r = idx / int'(TapSide);
        c = idx % int'(TapSide);
        for (int i = 0; i <= r; i++)
            emit_char(CharDot);
        emit_char(CharSpace);
        for (int i = 0; i <= c; i++)
            emit_char(CharDot);
        if (!last_flag)
            emit_char(CharSpace);
    endtask

    // Advance the group state by one character and queue the beats it causes.
    task automatic translate_char(input logic [7:0] ch, input logic last_flag);
        logic [7:0] lc;
        beat_t      b;
        step_chars.delete();
        lc = ch;
        if (ch >= CharUpA && ch <= CharUpZ)
            lc = ch - CharUpA + CharA;
        if (phase == PhaseSpare)
            phase = PhaseIdle;

        if (ch == CharDot) begin
            case (phase)
                PhaseIdle:
                begin
                    phase   = PhaseRow;
                    row_cnt = 3'd1;
                    col_cnt = 3'd0;
                end
                PhaseRow:
                begin
                    if (row_cnt < TapSat)
                        row_cnt++;
                end
                default:
                begin
                    if (col_cnt < TapSat)
                        col_cnt++;
                end
            endcase
        end else if (ch == CharSpace && phase == PhaseRow) begin
            phase = PhaseCol;
        end else begin
            close_group();
            if (lc >= CharA && lc <= CharZ)
                encode_letter(lc, last_flag);
        end

        if (last_flag) begin
            close_group();
            emit_char(CharNul);
        end

        foreach (step_chars[i]) begin
            b.code      = step_chars[i];
            b.last_flag = (i == step_chars.size() - 1);
            expected_beats.push_back(b);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t head;
        if (!rst_n) begin
            phase   = PhaseIdle;
            row_cnt = 3'd0;
            col_cnt = 3'd0;
            expected_beats.delete();
            fail_count = 0;
            pending_beats <= 0;
        end else begin
            if (push && !full)
                translate_char(in_char, in_last);
            if (pop && !empty) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected beat: out_char=%h run_last=%b", out_char, run_last);
                    fail_count++;
                end else begin
                    head = expected_beats.pop_front();
                    if (out_char !== head.code) begin
                        $error("out_char: expected %h, actual %h", head.code, out_char);
                        fail_count++;
                    end
                    if (run_last !== head.last_flag) begin
                        $error("run_last: expected %b, actual %b", head.last_flag, run_last);
                        fail_count++;
                    end
                end
            end
            pending_beats <= expected_beats.size();
        end
    end

endmodule

// File: tb/tap_code_translator_tb.sv
// Top of the tap code translator testbench: clock, reset, character stimulus,
// result stalls, watchdog and verdict. Depends on tct_pkg, the block and
// tap_code_checker, which does all prediction and comparison.
module tap_code_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tct_pkg::*;

    localparam int RandomItems = 500;
    localparam int HoldCycles  = 400;
    localparam int HoldAfter   = 120;
    localparam int IdleLimit   = 4000;

    typedef struct {
        logic [7:0] code;
        logic       last_flag;
    } char_item_t;

    typedef enum int {
        DrainFree,
        DrainCoin,
        DrainSparse,
        DrainMostly
    } drain_mode_e;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_char;
    logic       in_last;
    logic       empty;
    logic       pop;
    logic [7:0] out_char;
    logic       run_last;
    int         pending_beats;
    int         fail_count;

    char_item_t message_q[$];

    tap_code_translator DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_char  (in_char),
        .in_last  (in_last),
        .empty    (empty),
        .pop      (pop),
        .out_char (out_char),
        .run_last (run_last)
    );

    tap_code_checker checker_inst
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_char       (in_char),
        .in_last       (in_last),
        .empty         (empty),
        .pop           (pop),
        .out_char      (out_char),
        .run_last      (run_last),
        .pending_beats (pending_beats),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic add_char(input logic [7:0] c, input logic last_flag = 1'b0);
        char_item_t item;
        item.code      = c;
        item.last_flag = last_flag;
        message_q.push_back(item);
    endtask

    task automatic add_dots(input int n);
        for (int i = 0; i < n; i++)
            add_char(CharDot);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = CharA + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1))
            c = c - CharA + CharUpA;
        return c;
    endfunction

    // Closes a group: mostly a space, sometimes a letter or a stray byte.
    task automatic add_closer();
        int pick;
        logic [7:0] c;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            add_char(CharSpace);
        end else if (pick < 8) begin
            add_char(rand_letter());
        end else begin
            c = 8'($urandom_range(0, 255));
            add_char(c == CharDot ? 8'h7F : c);
        end
    endtask

    task automatic add_message();
        int tokens;
        int kind;
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                add_dots($urandom_range(1, 5));
                add_char(CharSpace);
                add_dots($urandom_range(1, 5));
                if ($urandom_range(0, 4) != 0)
                    add_closer();
            end else if (kind < 65) begin
                add_char(rand_letter());
            end else if (kind < 80) begin
                // broken group: long runs, missing column, doubled space
                add_dots($urandom_range(1, 8));
                case ($urandom_range(0, 2))
                    0: ;
                    1:
                    begin
                        add_char(CharSpace);
                        add_dots($urandom_range(0, 8));
                    end
                    default:
                    begin
                        add_char(CharSpace);
                        add_char(CharSpace);
                    end
                endcase
                if ($urandom_range(0, 3) != 0)
                    add_closer();
            end else begin
                add_char(8'($urandom_range(0, 255)));
            end
        end
        message_q[message_q.size() - 1].last_flag = 1'b1;
    endtask

    task automatic send_char(input char_item_t item);
        push    <= 1'b1;
        in_char <= item.code;
        in_last <= item.last_flag;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
    endtask

    // Result side: stall on changing patterns, and hold off once for a long stretch.
    initial
    begin
        drain_mode_e mode;
        int          mode_left;
        int          tick;
        int          pops_seen;
        bit          held;
        mode_left = 0;
        tick      = 0;
        pops_seen = 0;
        held      = 1'b0;
        mode      = DrainFree;
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (pop && !empty)
                pops_seen++;
            if (!held && pops_seen >= HoldAfter) begin
                pop <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                held = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = drain_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                tick++;
                case (mode)
                    DrainFree:   pop <= 1'b1;
                    DrainCoin:   pop <= 1'($urandom_range(0, 1));
                    DrainSparse: pop <= (tick % 4 == 0);
                    default:     pop <= ($urandom_range(0, 9) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit) begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int idx;
        int burst;
        int gap;
        int pause_at;
        push    <= 1'b0;
        in_char <= 8'h00;
        in_last <= 1'b0;
        rst_n   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // letters of both cases and k, a nul and a high byte
        add_char(CharUpA);
        add_char(CharK);
        add_char(8'h00);
        add_char(8'hFF);
        // first cell, closed by a space
        add_char(CharDot);
        add_char(CharSpace);
        add_char(CharDot);
        add_char(CharSpace);
        // last cell
        add_dots(5);
        add_char(CharSpace);
        add_dots(5);
        add_char(CharSpace);
        // space right after the separator
        add_char(CharDot);
        add_char(CharSpace);
        add_char(CharSpace);
        // a row dot without a space, then a letter ending the message
        add_char(CharDot);
        add_char(8'h78, 1'b1);

        while (message_q.size() < 25 + RandomItems)
            add_message();
        pause_at = message_q.size() / 2;

        idx = 0;
        while (idx < message_q.size()) begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            for (int b = 0; b < burst && idx < message_q.size(); b++) begin
                if (idx == pause_at) begin
                    push <= 1'b0;
                    wait_drained();
                end
                send_char(message_q[idx]);
                idx++;
            end
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b0;
        wait_drained();
        repeat (30) @(posedge clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
